// ===== hw/rtl/e2q_pkg.sv =====
// Package with shared types, constants and the CORDIC angle table.
`default_nettype none
package e2q_pkg;
    localparam int CordicSteps   = 24;
    localparam int AngleFracBits = 16;
    localparam int NumLanes      = 3;

    localparam logic [31:0] CRad      = 32'd2734261102;
    localparam logic [31:0] CDeg      = 32'd3054198966;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;
    localparam logic signed [33:0] OneQ30     = 34'sd1073741824;

    typedef struct packed {
        logic signed [31:0] bank_angle;
        logic signed [31:0] heading_angle;
        logic signed [31:0] attitude_angle;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [31:0] quat_w;
    } out_item_t;

    // Cosine and sine of one half angle, Q1.30 with headroom.
    typedef struct packed {
        logic signed [33:0] cs;
        logic signed [33:0] sn;
    } trig_t;

    function automatic logic signed [33:0] atan_turns(input int i);
        logic [31:0] t;
        case (i)
            0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
            3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
            6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
            9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
            12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
            15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
            18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
            21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
            24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
            27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
            30: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return $signed({2'b00, t});
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/euler_to_quaternion.sv =====
// Top level: three CORDIC lanes, a merging stage and the handshake control.
//   channel | direction | payload
//   s_      | in        | in_item_t (bank, heading, attitude)
//   m_      | out       | out_item_t (quat x, y, z, w)
//   cfg     | in        | angle_in_degrees write
// One item per cycle while no stall on m_ready holds the lane pipeline.
// The pipeline advances whenever the output register is empty or being taken.
// A stall on m_ready freezes the whole pipeline; s_ready then drops.
// Reset clears the valid bits and the degrees flag.
`default_nettype none
module euler_to_quaternion (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic                cfg_wr_data,
    input  wire logic                s_valid,
    output      logic                s_ready,
    input  wire e2q_pkg::in_item_t   s_data,
    output      logic                m_valid,
    input  wire logic                m_ready,
    output e2q_pkg::out_item_t       m_data
);
    localparam int Lat = e2q_pkg::CordicSteps + 6;

    logic deg_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) deg_reg <= 1'b0;
        else if (cfg_wr_en) deg_reg <= cfg_wr_data;
    end

    logic en;
    logic [Lat-1:0] vld_reg;
    assign en      = !vld_reg[Lat-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[Lat-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[Lat-2:0], s_valid};
    end

    e2q_pkg::trig_t th, ta, tb;
    e2q_lane u_head (.aclk(aclk), .en(en), .deg(deg_reg),
                     .angle(s_data.heading_angle), .trig(th));
    e2q_lane u_att  (.aclk(aclk), .en(en), .deg(deg_reg),
                     .angle(s_data.attitude_angle), .trig(ta));
    e2q_lane u_bank (.aclk(aclk), .en(en), .deg(deg_reg),
                     .angle(s_data.bank_angle), .trig(tb));
    e2q_merge u_merge (.aclk(aclk), .en(en), .t1(th), .t2(ta), .t3(tb), .res(m_data));

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("output lost");
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready) else $error("stalled while empty");
    a_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.quat_w <= 32'sd1073741824 && m_data.quat_w >= -32'sd1073741824))
        else $error("w out of range");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/e2q_lane.sv =====
// One lane: angle to phase, quadrant fold and a pipelined CORDIC.
`default_nettype none
module e2q_lane (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic               deg,
    input  wire logic signed [31:0] angle,
    output e2q_pkg::trig_t          trig
);
    localparam int N = e2q_pkg::CordicSteps;

    // Stage 0: phase product.
    logic signed [65:0] prod_reg;
    logic               deg_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= $signed({{34{angle[31]}}, angle}) *
                        $signed({34'd0, deg ? e2q_pkg::CDeg : e2q_pkg::CRad});
            deg_reg  <= deg;
        end
    end

    // Stage 1: rounding shift and quadrant.
    logic [65:0] pr_r, pr_d;
    logic [31:0] ph;
    logic [1:0]  quad;
    assign pr_r = 66'(prod_reg) + (66'd1 << (e2q_pkg::AngleFracBits + 2));
    assign pr_d = 66'(prod_reg) + (66'd1 << (e2q_pkg::AngleFracBits + 8));
    assign ph   = deg_reg ? pr_d[e2q_pkg::AngleFracBits + 9 +: 32]
                          : pr_r[e2q_pkg::AngleFracBits + 3 +: 32];
    logic [31:0] ph_q;
    assign ph_q = ph + 32'h20000000;
    assign quad = ph_q[31:30];

    logic signed [33:0] x_reg [N+1];
    logic signed [33:0] y_reg [N+1];
    logic signed [33:0] z_reg [N+1];
    logic [1:0]         q_reg [N+1];
    logic [31:0]        resid;
    assign resid = ph - {quad, 30'd0};

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= e2q_pkg::CordicGain;
            y_reg[0] <= '0;
            z_reg[0] <= 34'(signed'(resid));
            q_reg[0] <= quad;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_reg[i][33]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - e2q_pkg::atan_turns(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + e2q_pkg::atan_turns(i);
                end
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    always_comb begin
        case (q_reg[N])
            2'd0:    begin trig.cs = x_reg[N];  trig.sn = y_reg[N];  end
            2'd1:    begin trig.cs = -y_reg[N]; trig.sn = x_reg[N];  end
            2'd2:    begin trig.cs = -x_reg[N]; trig.sn = -y_reg[N]; end
            default: begin trig.cs = y_reg[N];  trig.sn = -x_reg[N]; end
        endcase
    end
endmodule
`default_nettype wire

// ===== hw/rtl/e2q_merge.sv =====
// Merging stage: quaternion products, rounding and saturation.
`default_nettype none
module e2q_merge (
    input  wire logic           aclk,
    input  wire logic           en,
    input  wire e2q_pkg::trig_t t1,
    input  wire e2q_pkg::trig_t t2,
    input  wire e2q_pkg::trig_t t3,
    output e2q_pkg::out_item_t  res
);
    logic signed [67:0] c1c2_reg, s1s2_reg, s1c2_reg, c1s2_reg;
    logic signed [33:0] c3_reg, s3_reg, c3b_reg, s3b_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            c1c2_reg <= t1.cs * t2.cs;
            s1s2_reg <= t1.sn * t2.sn;
            s1c2_reg <= t1.sn * t2.cs;
            c1s2_reg <= t1.cs * t2.sn;
            c3_reg   <= t3.cs;
            s3_reg   <= t3.sn;
        end
    end

    function automatic logic signed [33:0] rnd30(input logic signed [67:0] v);
        logic signed [67:0] t;
        t = v + 68'sd536870912;
        return 34'(t >>> 30);
    endfunction

    logic signed [33:0] a_reg, b_reg, c_reg, d_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg   <= rnd30(c1c2_reg);
            b_reg   <= rnd30(s1s2_reg);
            c_reg   <= rnd30(s1c2_reg);
            d_reg   <= rnd30(c1s2_reg);
            c3b_reg <= c3_reg;
            s3b_reg <= s3_reg;
        end
    end

    logic signed [67:0] as_reg, bc_reg, cc_reg, ds_reg, dc_reg, cs_reg, ac_reg, bs_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            as_reg <= a_reg * s3b_reg;  bc_reg <= b_reg * c3b_reg;
            cc_reg <= c_reg * c3b_reg;  ds_reg <= d_reg * s3b_reg;
            dc_reg <= d_reg * c3b_reg;  cs_reg <= c_reg * s3b_reg;
            ac_reg <= a_reg * c3b_reg;  bs_reg <= b_reg * s3b_reg;
        end
    end

    function automatic logic signed [31:0] fin(input logic signed [67:0] v);
        logic signed [33:0] r;
        r = rnd30(v);
        if (r > e2q_pkg::OneQ30) r = e2q_pkg::OneQ30;
        if (r < -e2q_pkg::OneQ30) r = -e2q_pkg::OneQ30;
        return r[31:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            res.quat_x <= fin(as_reg + bc_reg);
            res.quat_y <= fin(cc_reg + ds_reg);
            res.quat_z <= fin(dc_reg - cs_reg);
            res.quat_w <= fin(ac_reg - bs_reg);
        end
    end
endmodule
`default_nettype wire

// ===== test/euler_to_quaternion_tb.sv =====
// Self-checking testbench for the Euler-angle to quaternion converter.
`default_nettype none
module euler_to_quaternion_tb;
    localparam bit MODE_RAD = 1'b0;
    localparam bit MODE_DEG = 1'b1;
    localparam logic [63:0] RAD_TO_PHASE = 64'd2734261102;
    localparam logic [63:0] DEG_TO_PHASE = 64'd3054198966;
    localparam longint GAIN_Q30 = 64'sd652032874;
    localparam longint ONE_Q30  = 64'sd1073741824;
    localparam int STEPS = 24;
    localparam int DRAIN_CYCLES = 40;
    localparam int N_RANDOM = 600;
    localparam int Q16_PI = 205887;

    longint atan_tbl [0:STEPS-1] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_wr_data = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    e2q_pkg::in_item_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    e2q_pkg::out_item_t m_data;

    bit        deg_mode = MODE_RAD;
    bit        no_idle = 1'b0;
    bit        long_hold_done = 1'b0;
    int        n_accepted = 0;
    int        n_errors = 0;
    e2q_pkg::out_item_t quat_q[$];

    always #5 aclk = ~aclk;

    euler_to_quaternion u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    function automatic longint round_q30(input longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic [31:0] clamp_q30(input longint v);
        longint r;
        r = round_q30(v);
        if (r > ONE_Q30) r = ONE_Q30;
        if (r < -ONE_Q30) r = -ONE_Q30;
        return r[31:0];
    endfunction

    // Cosine and sine of the half angle, following the fixed-point CORDIC.
    function automatic void half_angle_trig(input logic [31:0] ang, input bit deg,
                                            output longint cs, output longint sn);
        logic [63:0] prod;
        logic [31:0] phase, resid;
        logic [1:0]  quad;
        longint x, y, z, dx, dy;
        int sh;
        sh = deg ? e2q_pkg::AngleFracBits + 9 : e2q_pkg::AngleFracBits + 3;
        prod = {{32{ang[31]}}, ang} * (deg ? DEG_TO_PHASE : RAD_TO_PHASE);
        prod = prod + (64'd1 << (sh - 1));
        phase = 32'(prod >> sh);
        quad = 2'((phase + 32'h20000000) >> 30);
        resid = phase - {quad, 30'b0};
        z = longint'($signed(resid));
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tbl[i];
            end else begin
                x += dx; y -= dy; z += atan_tbl[i];
            end
        end
        case (quad)
            2'd0: begin cs = x;  sn = y;  end
            2'd1: begin cs = -y; sn = x;  end
            2'd2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
        endcase
    endfunction

    function automatic e2q_pkg::out_item_t euler_to_quat(input e2q_pkg::in_item_t a,
                                                         input bit deg);
        longint ch, sh_, ca, sa, cb, sb, chca, shsa, shca, chsa;
        e2q_pkg::out_item_t r;
        half_angle_trig(a.heading_angle, deg, ch, sh_);
        half_angle_trig(a.attitude_angle, deg, ca, sa);
        half_angle_trig(a.bank_angle, deg, cb, sb);
        chca = round_q30(ch * ca);
        shsa = round_q30(sh_ * sa);
        shca = round_q30(sh_ * ca);
        chsa = round_q30(ch * sa);
        r.quat_x = clamp_q30(chca * sb + shsa * cb);
        r.quat_y = clamp_q30(shca * cb + chsa * sb);
        r.quat_z = clamp_q30(chsa * cb - shca * sb);
        r.quat_w = clamp_q30(chca * cb - shsa * sb);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        n_errors++;
    endtask

    // Input side: predict each accepted item.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            quat_q.push_back(euler_to_quat(s_data, deg_mode));
            n_accepted++;
        end
    end

    // Output side: compare each accepted result with the oldest prediction.
    always @(posedge aclk) begin
        e2q_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (quat_q.size() == 0) begin
                report_mismatch("unexpected result", m_data.quat_w, '0);
            end else begin
                want = quat_q.pop_front();
                if (m_data.quat_x !== want.quat_x) report_mismatch("x", m_data.quat_x, want.quat_x);
                if (m_data.quat_y !== want.quat_y) report_mismatch("y", m_data.quat_y, want.quat_y);
                if (m_data.quat_z !== want.quat_z) report_mismatch("z", m_data.quat_z, want.quat_z);
                if (m_data.quat_w !== want.quat_w) report_mismatch("w", m_data.quat_w, want.quat_w);
            end
        end
    end

    // Receiver: random stalls, one long hold-off once 150 items have been accepted.
    initial begin
        int k;
        @(posedge aresetn);
        forever begin
            if (!long_hold_done && n_accepted >= 150) begin
                long_hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (200) @(posedge aclk);
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                k = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
                m_ready <= 1'b0;
                repeat (k) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // The first edge lets the input monitor record an item accepted just before.
    task automatic wait_drained();
        @(posedge aclk);
        while (quat_q.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_mode(input bit deg);
        s_valid <= 1'b0;
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= deg;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        deg_mode = deg;
    endtask

    task automatic send_item(input e2q_pkg::in_item_t it);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 2) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 2);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 8 * Q16_PI) - 4 * Q16_PI;
            2: return $urandom_range(0, 1440 << 16) - (720 << 16);
            default: return $urandom_range(0, 2 * Q16_PI) - Q16_PI;
        endcase
    endfunction

    // Directed angles: zero, the code extremes, plus and minus one LSB, pi/2, multiples of pi and of 90 degrees.
    logic [31:0] directed_angles [0:11] = '{
        32'h00000000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h00000001,
        32'(Q16_PI), 32'(Q16_PI / 2), -32'(Q16_PI), 32'(90 << 16), 32'(180 << 16),
        32'(360 << 16), -32'(90 << 16)
    };

    initial begin
        e2q_pkg::in_item_t it;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int m = 0; m < 2; m++) begin
            write_mode(m ? MODE_DEG : MODE_RAD);
            for (int r = 0; r < 12; r++) begin
                it.bank_angle = directed_angles[r];
                it.heading_angle = directed_angles[(r + 4) % 12];
                it.attitude_angle = directed_angles[(r + 8) % 12];
                send_item(it);
            end
        end

        for (int p = 0; p < 3; p++) begin
            write_mode(p == 1 ? MODE_DEG : MODE_RAD);
            no_idle = (p == 2);
            for (int n = 0; n < N_RANDOM / 3; n++) begin
                it.bank_angle = rand_angle();
                it.heading_angle = rand_angle();
                it.attitude_angle = rand_angle();
                send_item(it);
            end
        end
        s_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #50000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
